[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop on every rising clk edge while rstn is high.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check prop on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[hw/rtl/ctn_pkg.sv]
// ----------------------------------------------------------------------------
// ctn_pkg
// Types, character codes and the symbol map for the chat text normaliser.
// ----------------------------------------------------------------------------
package ctn_pkg;

    localparam logic [7:0] CHR_CARET  = 8'h5E;
    localparam logic [7:0] CHR_AT     = 8'h40;
    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_BAR    = 8'h7C;
    localparam logic [7:0] CHR_USCORE = 8'h5F;
    localparam logic [7:0] CHR_BANG   = 8'h21;
    localparam logic [7:0] CHR_LPAREN = 8'h28;
    localparam logic [7:0] CHR_RPAREN = 8'h29;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_DASH   = 8'h2D;
    localparam logic [7:0] CHR_DOT    = 8'h2E;
    localparam logic [7:0] CHR_SLASH  = 8'h2F;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_0      = 8'h30;
    localparam logic [7:0] CHR_1      = 8'h31;
    localparam logic [7:0] CHR_3      = 8'h33;
    localparam logic [7:0] CHR_4      = 8'h34;
    localparam logic [7:0] CHR_5      = 8'h35;
    localparam logic [7:0] CHR_9      = 8'h39;
    localparam logic [7:0] CHR_UP_A   = 8'h41;
    localparam logic [7:0] CHR_UP_Z   = 8'h5A;
    localparam logic [7:0] CHR_LO_A   = 8'h61;
    localparam logic [7:0] CHR_LO_C   = 8'h63;
    localparam logic [7:0] CHR_LO_D   = 8'h64;
    localparam logic [7:0] CHR_LO_E   = 8'h65;
    localparam logic [7:0] CHR_LO_I   = 8'h69;
    localparam logic [7:0] CHR_LO_O   = 8'h6F;
    localparam logic [7:0] CHR_LO_S   = 8'h73;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // One result request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_result;
    } res_t;

    // Mapped byte and whether it survives
    typedef struct packed {
        logic       keep;
        logic [7:0] value;
    } map_t;

    function automatic map_t map_byte(input logic [7:0] b);
        map_t m;
        m.keep  = 1'b1;
        m.value = b;
        if (b >= CHR_UP_A && b <= CHR_UP_Z) begin
            m.value = b + CASE_DELTA;
        end else begin
            case (b)
                CHR_4, CHR_AT:             m.value = CHR_LO_A;
                CHR_LPAREN:                m.value = CHR_LO_C;
                CHR_RPAREN:                m.value = CHR_LO_D;
                CHR_3:                     m.value = CHR_LO_E;
                CHR_1, CHR_BAR, CHR_BANG:  m.value = CHR_LO_I;
                CHR_0:                     m.value = CHR_LO_O;
                CHR_5, CHR_DOLLAR:         m.value = CHR_LO_S;
                CHR_DOT, CHR_COMMA, CHR_BSLASH,
                CHR_SLASH, CHR_DASH, CHR_USCORE: m.keep = 1'b0;
                default:                   m.value = b;
            endcase
        end
        return m;
    endfunction

endpackage

[hw/rtl/chat_text_normalizer.sv]
// ----------------------------------------------------------------------------
// chat_text_normalizer
// Strips colour codes, folds case and look-alike symbols, and collapses runs
// of equal bytes in a chat message streamed one byte per request.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                                  | handshake
//  --------+-----------+------------------------------------------+-------------------
//  s_      | in        | in_byte[7:0], end_of_message             | s_valid / s_ready
//  m_      | out       | out_byte[7:0], byte_valid, last_result   | m_valid / m_ready
//
//  Cycles : a byte is decoded in the cycle it is accepted and its results
//           enter the result queue; one byte per cycle while s_ready is high.
//  Limit  : the result queue drains one request per cycle while m_ready is
//           high, so a byte that also releases a held caret leaves two results.
//  Stalls : s_ready is high while the three-entry result queue holds at most
//           one request, so input keeps flowing while a result waits.
//  Reset  : aresetn (synchronous, active low) empties the queue and clears
//           the caret and run-collapse state.
//
module chat_text_normalizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_last_result
);
    import ctn_pkg::*;

    `include "assert_macros.svh"

    localparam int unsigned QDEPTH = 3;

    // Message state
    logic       caret_pending_reg, caret_pending_next;
    logic [7:0] prev_byte_reg, prev_byte_next;
    logic       prev_valid_reg, prev_valid_next;

    // Result queue: head in slot 0, shifts down on every pop
    res_t       q_reg [QDEPTH];
    res_t       q_next [QDEPTH];
    res_t       q_shift [QDEPTH];
    logic [1:0] count_reg, count_next;
    logic [1:0] base;

    logic       s_fire, m_fire;
    logic       is_digit;
    logic       caret_hit, caret_emit;
    logic       take_cur, cur_pend, cur_emit, marker;
    logic       pv1;
    logic [7:0] pb1;
    map_t       cur_map;
    res_t       push0, push1;
    logic [1:0] n_push;

    assign s_ready = (count_reg <= 2'd1);
    assign m_valid = (count_reg != 2'd0);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    assign m_out_byte    = q_reg[0].out_byte;
    assign m_byte_valid  = q_reg[0].byte_valid;
    assign m_last_result = q_reg[0].last_result;

    // ------------------------------------------------------------------
    // Per-byte decode
    // ------------------------------------------------------------------
    always_comb begin
        is_digit = (s_in_byte >= CHR_0) && (s_in_byte <= CHR_9);

        // A held caret not followed by a digit is released ahead of this byte
        caret_hit  = caret_pending_reg && !is_digit;
        caret_emit = caret_hit && !(prev_valid_reg && prev_byte_reg == CHR_CARET);

        // Run state as seen by the current byte
        pv1 = prev_valid_reg || caret_hit;
        pb1 = caret_hit ? CHR_CARET : prev_byte_reg;

        // Caret followed by a digit: drop both
        take_cur = !(caret_pending_reg && is_digit);
        // Hold a new caret, unless the message ends here
        cur_pend = take_cur && (s_in_byte == CHR_CARET) && !s_end_of_message;
        cur_map  = map_byte(s_in_byte);
        cur_emit = take_cur && !cur_pend && cur_map.keep &&
                   !(pv1 && cur_map.value == pb1);

        // Bare end marker when the final byte yields nothing
        marker = s_end_of_message && !caret_emit && !cur_emit;

        push0 = '{out_byte: 8'h00, byte_valid: 1'b0, last_result: 1'b1};
        push1 = '{out_byte: cur_map.value, byte_valid: 1'b1,
                  last_result: s_end_of_message};
        if (caret_emit) begin
            push0 = '{out_byte: CHR_CARET, byte_valid: 1'b1,
                      last_result: s_end_of_message && !cur_emit};
        end else if (cur_emit) begin
            push0 = push1;
        end

        if (caret_emit && cur_emit) begin
            n_push = 2'd2;
        end else if (caret_emit || cur_emit || marker) begin
            n_push = 2'd1;
        end else begin
            n_push = 2'd0;
        end

        // Advance message state; clear it after the final byte
        caret_pending_next = caret_pending_reg;
        prev_byte_next     = prev_byte_reg;
        prev_valid_next    = prev_valid_reg;
        if (s_fire) begin
            if (s_end_of_message) begin
                caret_pending_next = 1'b0;
                prev_byte_next     = 8'h00;
                prev_valid_next    = 1'b0;
            end else begin
                caret_pending_next = cur_pend;
                prev_byte_next     = cur_emit ? cur_map.value : pb1;
                prev_valid_next    = pv1 || cur_emit;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue update
    // ------------------------------------------------------------------
    always_comb begin
        q_shift[0] = m_fire ? q_reg[1] : q_reg[0];
        q_shift[1] = m_fire ? q_reg[2] : q_reg[1];
        q_shift[2] = q_reg[2];

        base = count_reg - {1'b0, m_fire};

        for (int i = 0; i < QDEPTH; i++) begin
            q_next[i] = q_shift[i];
            if (s_fire) begin
                if (2'(i) == base) begin
                    q_next[i] = push0;
                end else if (2'(i) == base + 2'd1 && n_push == 2'd2) begin
                    q_next[i] = push1;
                end
            end
        end

        count_next = base + (s_fire ? n_push : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            caret_pending_reg <= 1'b0;
            prev_byte_reg     <= 8'h00;
            prev_valid_reg    <= 1'b0;
            count_reg         <= 2'd0;
        end else begin
            caret_pending_reg <= caret_pending_next;
            prev_byte_reg     <= prev_byte_next;
            prev_valid_reg    <= prev_valid_next;
            count_reg         <= count_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_eom_clears, aclk, aresetn, (s_fire && s_end_of_message) |=> (!caret_pending_reg && !prev_valid_reg && prev_byte_reg == 8'h00), "message state not cleared after final byte")
    `ASSERT_CLK(a_marker_last, aclk, aresetn, (m_valid && !m_byte_valid) |-> (m_last_result && m_out_byte == 8'h00), "bare end marker malformed")
    `ASSERT_CLK(a_pop_only, aclk, aresetn, (m_fire && !s_fire) |=> (count_reg == $past(count_reg) - 2'd1), "queue count wrong on pop")
    `ASSERT_CLK(a_pend_not_eom, aclk, aresetn, (s_fire && s_end_of_message && s_in_byte == CHR_CARET) |-> (n_push != 2'd0), "trailing caret lost")
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (count_reg == 2'd0), "queue not empty after reset")

endmodule

[test/chat_text_normalizer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chat_text_normalizer_checker
// Watches both channels of the text normaliser, predicts the result requests
// of every accepted byte and compares them with what the block returns.
// ----------------------------------------------------------------------------
module chat_text_normalizer_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_message,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_byte_valid,
    input  logic       m_last_result,
    output int         fail_count,
    output int         chars_awaited
);
    import ctn_pkg::*;

    // Stage two as a lookup table: folded value and whether the byte survives
    logic [7:0] folded   [256];
    bit         survives [256];

    // Predictor state
    bit         caret_held;
    logic [7:0] run_byte;
    bit         run_valid;

    res_t       pending_chars [$];

    initial begin : build_fold_table
        for (int c = 0; c < 256; c++) begin
            folded[c]   = 8'(c);
            survives[c] = 1'b1;
            if (8'(c) >= CHR_UP_A && 8'(c) <= CHR_UP_Z) begin
                folded[c] = 8'(c) + CASE_DELTA;
            end
        end
        folded[CHR_4]      = CHR_LO_A;
        folded[CHR_AT]     = CHR_LO_A;
        folded[CHR_LPAREN] = CHR_LO_C;
        folded[CHR_RPAREN] = CHR_LO_D;
        folded[CHR_3]      = CHR_LO_E;
        folded[CHR_1]      = CHR_LO_I;
        folded[CHR_BAR]    = CHR_LO_I;
        folded[CHR_BANG]   = CHR_LO_I;
        folded[CHR_0]      = CHR_LO_O;
        folded[CHR_5]      = CHR_LO_S;
        folded[CHR_DOLLAR] = CHR_LO_S;
        survives[CHR_DOT]    = 1'b0;
        survives[CHR_COMMA]  = 1'b0;
        survives[CHR_BSLASH] = 1'b0;
        survives[CHR_SLASH]  = 1'b0;
        survives[CHR_DASH]   = 1'b0;
        survives[CHR_USCORE] = 1'b0;
    end

    // Fold one byte; drop it when it does not survive or repeats the last emitted one
    task automatic fold_and_squash(input logic [7:0] b);
        res_t r;
        if (!survives[b]) return;
        if (run_valid && folded[b] == run_byte) return;
        run_byte      = folded[b];
        run_valid     = 1'b1;
        r.out_byte    = folded[b];
        r.byte_valid  = 1'b1;
        r.last_result = 1'b0;
        pending_chars.push_back(r);
    endtask

    task automatic normalise_byte(input logic [7:0] b, input logic eom);
        int   before_count;
        bit   take_current;
        res_t r;
        before_count = pending_chars.size();
        take_current = 1'b1;
        if (caret_held) begin
            caret_held = 1'b0;
            if (b >= CHR_0 && b <= CHR_9) begin
                take_current = 1'b0;
            end else begin
                fold_and_squash(CHR_CARET);
            end
        end
        if (take_current) begin
            if (b == CHR_CARET && !eom) begin
                caret_held = 1'b1;
            end else begin
                fold_and_squash(b);
            end
        end
        if (eom) begin
            if (pending_chars.size() == before_count) begin
                r.out_byte    = 8'h00;
                r.byte_valid  = 1'b0;
                r.last_result = 1'b1;
            end else begin
                r = pending_chars.pop_back();
                r.last_result = 1'b1;
            end
            pending_chars.push_back(r);
            caret_held = 1'b0;
            run_byte   = 8'h00;
            run_valid  = 1'b0;
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            caret_held = 1'b0;
            run_byte   = 8'h00;
            run_valid  = 1'b0;
            pending_chars.delete();
        end else begin
            if (s_valid && s_ready) begin
                normalise_byte(s_in_byte, s_end_of_message);
            end
            if (m_valid && m_ready) begin
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h/%0b/%0b",
                             $time, m_out_byte, m_byte_valid, m_last_result);
                    fail_count++;
                end else begin
                    want = pending_chars.pop_front();
                    report_field("out_byte", want.out_byte, m_out_byte);
                    report_field("byte_valid", want.byte_valid, m_byte_valid);
                    report_field("last_result", want.last_result, m_last_result);
                end
            end
        end
        chars_awaited = pending_chars.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams chat messages into the text normaliser: a short directed set of
// colour codes, trailing carets and runs, then random messages under bursty
// input and a stalling receiver. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import ctn_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_end_of_message;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_last_result;

    int         fail_count;
    int         chars_awaited;

    // Sender bookkeeping
    int         burst_left;
    int         bytes_offered;
    // Raised once to make the receiver hold off for a long stretch
    bit         long_hold_req;

    chat_text_normalizer u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_byte_valid     (m_byte_valid),
        .m_last_result    (m_last_result)
    );

    chat_text_normalizer_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_byte_valid     (m_byte_valid),
        .m_last_result    (m_last_result),
        .fail_count       (fail_count),
        .chars_awaited    (chars_awaited)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: several times the slowest correct run
    initial begin
        #6_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Receiver: switch between always ready, single-cycle drops and longer
    // stalls, and serve one long hold-off when the stimulus asks for it.
    initial begin : sink_side
        int stall_left;
        int mode;
        int mode_left;
        bit hold_seen;
        bit hold_served;
        m_ready     = 1'b0;
        stall_left  = 0;
        mode        = 0;
        mode_left   = 0;
        hold_served = 1'b0;
        forever begin
            // sample the request flag at the rising edge, act at the falling one
            @(posedge aclk);
            hold_seen = long_hold_req;
            @(negedge aclk);
            if (hold_seen && !hold_served) begin
                hold_served = 1'b1;
                m_ready     = 1'b0;
                repeat (300) @(negedge aclk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 250);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                m_ready = 1'b0;
            end else if (mode == 1 && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
            end else if (mode == 2 && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7);
                m_ready    = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Offer one request and hold it until accepted. Between bursts, drop valid
    // for a random gap unless the caller wants a steady stream.
    task automatic offer_byte(input logic [7:0] b, input logic eom, input bit no_gaps);
        int gap;
        if (!no_gaps && burst_left == 0) begin
            gap     = $urandom_range(1, 12);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        s_valid          = 1'b1;
        s_in_byte        = b;
        s_end_of_message = eom;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_offered++;
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_until_drained();
        s_valid = 1'b0;
        while (chars_awaited != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Text-like byte: letters, look-alikes, dropped punctuation, carets that
    // are mostly followed by a digit, repeats, and the odd arbitrary byte.
    function automatic logic [7:0] pick_text_byte(input logic [7:0] prev);
        int         roll;
        logic [7:0] v;
        if (prev == CHR_CARET && $urandom_range(0, 9) < 7) begin
            return 8'(CHR_0 + $urandom_range(0, 9));
        end
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            v = 8'(CHR_UP_A + $urandom_range(0, 25));
        end else if (roll < 30) begin
            v = 8'(CHR_LO_A + $urandom_range(0, 25));
        end else if (roll < 45) begin
            case ($urandom_range(0, 10))
                0:       v = CHR_4;
                1:       v = CHR_AT;
                2:       v = CHR_LPAREN;
                3:       v = CHR_RPAREN;
                4:       v = CHR_3;
                5:       v = CHR_1;
                6:       v = CHR_BAR;
                7:       v = CHR_BANG;
                8:       v = CHR_0;
                9:       v = CHR_5;
                default: v = CHR_DOLLAR;
            endcase
        end else if (roll < 55) begin
            case ($urandom_range(0, 5))
                0:       v = CHR_DOT;
                1:       v = CHR_COMMA;
                2:       v = CHR_BSLASH;
                3:       v = CHR_SLASH;
                4:       v = CHR_DASH;
                default: v = CHR_USCORE;
            endcase
        end else if (roll < 65) begin
            v = CHR_CARET;
        end else if (roll < 75) begin
            v = 8'(CHR_0 + $urandom_range(0, 9));
        end else if (roll < 87) begin
            v = prev;
        end else begin
            v = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    task automatic send_message(input int len, input bit no_gaps);
        logic [7:0] prev;
        logic [7:0] b;
        prev = 8'h00;
        for (int i = 0; i < len; i++) begin
            b = pick_text_byte(prev);
            offer_byte(b, i == len - 1, no_gaps);
            prev = b;
        end
    endtask

    initial begin : source_side
        int start_count;
        bit hold_done;
        bit drain_done;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_in_byte        = 8'h00;
        s_end_of_message = 1'b0;
        long_hold_req    = 1'b0;
        burst_left       = 0;
        bytes_offered    = 0;
        hold_done        = 1'b0;
        drain_done       = 1'b0;

        // hold reset, then release it at a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // colour code dropped: "^3Hi" gives "hi"
        offer_byte(CHR_CARET, 1'b0, 1'b0);
        offer_byte(CHR_3,     1'b0, 1'b0);
        offer_byte(8'h48,     1'b0, 1'b0);
        offer_byte(8'h69,     1'b1, 1'b0);
        // caret then a non-digit on the last byte: both come out
        offer_byte(CHR_CARET, 1'b0, 1'b0);
        offer_byte(8'h78,     1'b1, 1'b0);
        // caret releases a held caret and becomes pending; the digit then
        // eats it, leaving a bare end marker
        offer_byte(CHR_CARET, 1'b0, 1'b0);
        offer_byte(CHR_CARET, 1'b0, 1'b0);
        offer_byte(CHR_5,     1'b1, 1'b0);
        // trailing caret on its own
        offer_byte(CHR_CARET, 1'b1, 1'b0);
        // nothing survives: bare end marker
        offer_byte(CHR_DOT,   1'b1, 1'b0);
        // run across folding and dropped punctuation collapses to one "a"
        offer_byte(CHR_UP_A,  1'b0, 1'b0);
        offer_byte(CHR_LO_A,  1'b0, 1'b0);
        offer_byte(CHR_4,     1'b0, 1'b0);
        offer_byte(CHR_AT,    1'b0, 1'b0);
        offer_byte(CHR_USCORE, 1'b0, 1'b0);
        offer_byte(CHR_LO_A,  1'b1, 1'b0);
        // field extremes and the zero byte, then a held caret released by
        // a non-digit final byte
        offer_byte(8'h00,     1'b0, 1'b0);
        offer_byte(8'hFF,     1'b0, 1'b0);
        offer_byte(8'h01,     1'b0, 1'b0);
        offer_byte(8'h80,     1'b0, 1'b0);
        offer_byte(CHR_CARET, 1'b0, 1'b0);
        offer_byte(8'h7F,     1'b1, 1'b0);
        // colour code as the whole message
        offer_byte(CHR_CARET, 1'b0, 1'b0);
        offer_byte(CHR_9,     1'b1, 1'b0);

        wait_until_drained();

        // random messages, mostly short, some long
        while (bytes_offered < 1940) begin
            if (!hold_done && bytes_offered >= 600) begin
                // receiver holds off while a steady stream fills the block
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
                start_count   = bytes_offered;
                while (bytes_offered < start_count + 48) begin
                    send_message($urandom_range(4, 12), 1'b1);
                end
            end
            if (!drain_done && bytes_offered >= 1300) begin
                drain_done = 1'b1;
                wait_until_drained();
            end
            send_message(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12), 1'b0);
        end

        // let the last results out, then let the clock run on before reporting
        wait_until_drained();
        repeat (20) @(posedge aclk);

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ctn_pkg.sv
hw/rtl/chat_text_normalizer.sv
test/chat_text_normalizer_checker.sv
test/testbench.sv
